### src/miller_rabin_prime_test_defines.svh
// Assertion macros used by the prime test block.
// Each macro assumes a clock named clk and an active-low reset named arst_n.
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH

// Same-cycle implication.
`define MRPT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prime test assertion failed");

// Next-cycle implication.
`define MRPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prime test assertion failed");

`endif

### src/mrpt_pkg.sv
`timescale 1ns / 1ps

package mrpt_pkg;

	localparam int NUMBER_BITS   = 32;
	localparam int NUM_WIDTH_DEF = 32;
	localparam int NUM_BASES     = 3;
	localparam int BASE_BITS     = 8;

	typedef logic [1:0] base_idx_t;

	localparam base_idx_t LAST_BASE = base_idx_t'(NUM_BASES - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_BASE,
		S_STRIP,
		S_RED,
		S_RED_W,
		S_EXP,
		S_MULA_W,
		S_SQR,
		S_SQR_W,
		S_TEST,
		S_TSQ_W,
		S_DONE
	} mr_state_t;

	function automatic logic [BASE_BITS-1:0] witness_base(input base_idx_t k);
		logic [BASE_BITS-1:0] b;
		case (k)
			2'd0: b = BASE_BITS'(2);
			2'd1: b = BASE_BITS'(3);
			default: b = BASE_BITS'(61);
		endcase
		return b;
	endfunction

endpackage

### src/miller_rabin_prime_test.sv
`timescale 1ns / 1ps

// Channel   Ports                 Handshake
// input     number[31:0]          word taken when start is high and busy is low
// result    is_prime              word valid for the one cycle that done is high
//
// A number settled by the special cases (top bit set, below two, two, even) goes from S_CHECK
// straight to S_DONE. For an odd number, each modular product is formed in the bit-serial
// multiplier, and each bit of the exponent needs up to two of them.
// Reset is asynchronous and returns the controller to idle; no state survives a word.
// The receiver cannot stall: done is a single-cycle strobe and busy falls after it.
`include "miller_rabin_prime_test_defines.svh"

module miller_rabin_prime_test import mrpt_pkg::*; #(
	parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [NUMBER_BITS-1:0] number,
	output logic                   done,
	output logic                   is_prime
);

	localparam int W = NUM_WIDTH;
	localparam logic [W-1:0] ONE = W'(1);
	localparam logic [W-1:0] TWO = W'(2);

	mr_state_t state_q;
	mr_state_t nxt_state;

	logic [W-1:0] n_q;
	logic [W-1:0] nm1_q;
	logic [W-1:0] d_q;
	logic [W-1:0] e_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] sq_q;
	base_idx_t    k_q;
	logic         prime_q;

	logic         mm_start;
	logic [W-1:0] mm_a;
	logic [W-1:0] mm_b;
	logic         mm_done;
	logic [W-1:0] mm_res;

	logic [W-1:0] base_w;
	logic         trivial;
	logic         n_is_base;
	logic         test_go;
	logic         base_pass;
	logic         last_base;
	logic         e_zero;
	logic         mm_wait;

	always_comb begin
		base_w    = W'(witness_base(k_q));
		trivial   = n_q[W-1] || (n_q < TWO) || !n_q[0];
		n_is_base = (n_q == base_w);
		test_go   = (d_q != nm1_q) && (acc_q != ONE) && (acc_q != nm1_q);
		base_pass = (acc_q == nm1_q) || d_q[0];
		last_base = (k_q == LAST_BASE);
		e_zero    = (e_q == '0);
		mm_wait   = (state_q == S_RED_W) || (state_q == S_MULA_W) ||
		            (state_q == S_SQR_W) || (state_q == S_TSQ_W);
	end

	mrpt_modmul #(
		.W(W)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.a     (mm_a),
		.b     (mm_b),
		.m     (n_q),
		.done  (mm_done),
		.result(mm_res)
	);

	// Next state.
	always_comb begin
		nxt_state = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) nxt_state = S_CHECK;
			end
			S_CHECK: begin
				// Two is the only even number that is not rejected here.
				if (trivial || n_q == TWO) nxt_state = S_DONE;
				else nxt_state = S_BASE;
			end
			S_BASE: begin
				if (!n_is_base) nxt_state = S_STRIP;
				else if (last_base) nxt_state = S_DONE;
			end
			S_STRIP: begin
				if (d_q[0]) nxt_state = S_RED;
			end
			S_RED: nxt_state = S_RED_W;
			S_RED_W: begin
				if (mm_done) nxt_state = S_EXP;
			end
			S_EXP: begin
				if (e_zero) nxt_state = S_TEST;
				else if (e_q[0]) nxt_state = S_MULA_W;
				else nxt_state = S_SQR;
			end
			S_MULA_W: begin
				if (mm_done) nxt_state = S_SQR;
			end
			S_SQR: nxt_state = S_SQR_W;
			S_SQR_W: begin
				if (mm_done) nxt_state = S_EXP;
			end
			S_TEST: begin
				if (test_go) nxt_state = S_TSQ_W;
				else if (!base_pass || last_base) nxt_state = S_DONE;
				else nxt_state = S_BASE;
			end
			S_TSQ_W: begin
				if (mm_done) nxt_state = S_TEST;
			end
			S_DONE: nxt_state = S_IDLE;
			default: nxt_state = S_IDLE;
		endcase
	end

	// Outputs and multiplier launches.
	always_comb begin
		busy     = (state_q != S_IDLE);
		done     = (state_q == S_DONE);
		is_prime = prime_q;
		mm_start = 1'b0;
		mm_a     = acc_q;
		mm_b     = sq_q;
		case (state_q)
			S_RED: begin
				// The base reduced modulo n, as the product of one and the base.
				mm_start = 1'b1;
				mm_a     = ONE;
				mm_b     = base_w;
			end
			S_EXP: begin
				mm_start = !e_zero && e_q[0];
			end
			S_SQR: begin
				mm_start = 1'b1;
				mm_a     = sq_q;
			end
			S_TEST: begin
				mm_start = test_go;
				mm_b     = acc_q;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			prime_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			case (state_q)
				S_IDLE: begin
					if (start) n_q <= number[W-1:0];
				end
				S_CHECK: begin
					nm1_q   <= n_q - ONE;
					k_q     <= '0;
					prime_q <= !trivial || (n_q == TWO);
				end
				S_BASE: begin
					if (n_is_base) begin
						if (!last_base) k_q <= k_q + 1'b1;
					end else begin
						d_q <= nm1_q;
					end
				end
				S_STRIP: begin
					if (d_q[0]) begin
						e_q   <= d_q;
						acc_q <= ONE;
					end else begin
						d_q <= {1'b0, d_q[W-1:1]};
					end
				end
				S_RED_W: begin
					if (mm_done) sq_q <= mm_res;
				end
				S_MULA_W: begin
					if (mm_done) acc_q <= mm_res;
				end
				S_SQR_W: begin
					if (mm_done) begin
						sq_q <= mm_res;
						e_q  <= {1'b0, e_q[W-1:1]};
					end
				end
				S_TEST: begin
					if (!test_go) begin
						if (!base_pass) prime_q <= 1'b0;
						else if (!last_base) k_q <= k_q + 1'b1;
					end
				end
				S_TSQ_W: begin
					if (mm_done) begin
						acc_q <= mm_res;
						d_q   <= {d_q[W-2:0], 1'b0};
					end
				end
				default: begin
					prime_q <= prime_q;
				end
			endcase
		end
	end

	`MRPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`MRPT_ASSERT_NEXT(a_done_release, done, !busy)
	`MRPT_ASSERT_IMPL(a_mm_done_waiting, mm_done, mm_wait)
	`MRPT_ASSERT_IMPL(a_prime_odd, done && is_prime, n_q == TWO || n_q[0])

endmodule

### src/mrpt_modmul.sv
`timescale 1ns / 1ps

// Interleaved modular multiplier: one bit of the multiplier per cycle, MSB first.
// The accumulator is doubled and the multiplicand added in one step, and the sum,
// which stays below three times the modulus, is reduced by a parallel compare
// against the modulus and twice the modulus.
module mrpt_modmul import mrpt_pkg::*; #(
	parameter int W = NUM_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] result
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  m_q;

	logic [W:0]   sum;
	logic [W:0]   m1;
	logic [W:0]   m2;
	logic [W:0]   red;

	always_comb begin
		m1  = {1'b0, m_q};
		m2  = {m_q, 1'b0};
		sum = {acc_q, 1'b0} + (b_q[W-1] ? {1'b0, a_q} : '0);
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
				acc_q  <= '0;
				a_q    <= a;
				b_q    <= b;
				m_q    <= m;
			end else if (busy_q) begin
				acc_q <= red[W-1:0];
				b_q   <= {b_q[W-2:0], 1'b0};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

### verif/tb_miller_rabin_prime_test.sv
`timescale 1ns / 1ps

module tb_miller_rabin_prime_test;
	import mrpt_pkg::*;

	typedef struct {
		logic [NUMBER_BITS-1:0] number;
		bit                     is_prime;
	} verdict_t;

	typedef enum int {
		PICK_ODD,
		PICK_SMALL_ODD,
		PICK_NEGATIVE,
		PICK_EVEN,
		PICK_PRODUCT,
		PICK_KNOWN_PRIME
	} pick_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [NUMBER_BITS-1:0] number;
	logic                   done;
	logic                   is_prime;

	verdict_t pending_verdicts[$];
	int       error_count = 0;

	logic [NUMBER_BITS-1:0] known_primes [7] = '{
		32'd2147483647, 32'd2147483629, 32'd1000000007, 32'd998244353,
		32'd65537, 32'd104729, 32'd7919
	};

	miller_rabin_prime_test u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.number   (number),
		.done     (done),
		.is_prime (is_prime)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[miller_rabin_prime_test] ERROR");
		$finish;
	end

	// Deterministic Miller-Rabin with bases 2, 3 and 61, in 64-bit arithmetic so that
	// every product of two residues below 2^32 fits.
	function automatic bit predict_prime(input logic [NUMBER_BITS-1:0] value);
		longint unsigned n, nm1, d, t, b, sq, e;
		int k;
		n = {32'd0, value};
		if (value[NUMBER_BITS-1] || n < 2)
			return 1'b0;
		if (n == 2)
			return 1'b1;
		if (!n[0])
			return 1'b0;
		for (k = 0; k < 3; k++) begin
			b = (k == 0) ? 2 : (k == 1) ? 3 : 61;
			if (n != b) begin
				nm1 = n - 1;
				d = nm1;
				while (!d[0])
					d = d >> 1;
				t = 1;
				sq = b % n;
				e = d;
				while (e != 0) begin
					if (e[0])
						t = (t * sq) % n;
					sq = (sq * sq) % n;
					e = e >> 1;
				end
				while (d != nm1 && t != 1 && t != nm1) begin
					t = (t * t) % n;
					d = d << 1;
				end
				if (!(t == nm1 || d[0]))
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic flag_error(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Called at a rising edge; leaves start high so that a following word goes straight on.
	task automatic send_word(input logic [NUMBER_BITS-1:0] value);
		verdict_t v;
		start  <= 1'b1;
		number <= value;
		do @(posedge clk); while (busy !== 1'b0);
		v.number   = value;
		v.is_prime = predict_prime(value);
		pending_verdicts.push_back(v);
	endtask

	task automatic maybe_idle(input bit allow);
		int gap;
		if (allow && $urandom_range(0, 99) < 25) begin
			gap = $urandom_range(1, 8);
			start  <= 1'b0;
			number <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [NUMBER_BITS-1:0] random_number();
		logic [NUMBER_BITS-1:0] value;
		int roll;
		pick_t pick;
		roll = $urandom_range(0, 99);
		pick = (roll < 50) ? PICK_ODD : (roll < 60) ? PICK_SMALL_ODD :
		       (roll < 70) ? PICK_NEGATIVE : (roll < 78) ? PICK_EVEN :
		       (roll < 90) ? PICK_PRODUCT : PICK_KNOWN_PRIME;
		value = $urandom;
		case (pick)
			PICK_ODD: begin
				value[NUMBER_BITS-1] = 1'b0;
				value[0] = 1'b1;
			end
			PICK_SMALL_ODD: value = $urandom_range(1, 1000) * 2 + 1;
			PICK_NEGATIVE: value[NUMBER_BITS-1] = 1'b1;
			PICK_EVEN: value[0] = 1'b0;
			PICK_PRODUCT: value = ($urandom_range(1, 23169) * 2 + 1) *
			                      ($urandom_range(1, 23169) * 2 + 1);
			default: value = known_primes[$urandom_range(0, 6)];
		endcase
		return value;
	endfunction

	always @(posedge clk) begin : check_words
		verdict_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_verdicts.size() == 0) begin
				flag_error("result word with no word outstanding");
			end else begin
				want = pending_verdicts.pop_front();
				if (is_prime !== want.is_prime)
					flag_error($sformatf("number %0d: is_prime %b, predicted %b",
						$signed(want.number), is_prime, want.is_prime));
			end
		end
	end

	// Values below two, two itself, the bases, evens and the range limits.
	task automatic test_special_cases();
		logic [NUMBER_BITS-1:0] values [13] = '{
			32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd2, 32'd3, 32'd4,
			32'd61, 32'd62, 32'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd65537
		};
		int i;
		for (i = 0; i < 13; i++) begin
			send_word(values[i]);
			maybe_idle(1'b1);
		end
	endtask

	// Composites that fool some of the bases, and a prime square near the top of the range.
	task automatic test_pseudoprimes();
		logic [NUMBER_BITS-1:0] values [8] = '{
			32'd2047, 32'd1373653, 32'd25326001, 32'd561, 32'd1105,
			32'd3215031751, 32'd2147117569, 32'd121
		};
		int i;
		for (i = 0; i < 8; i++) begin
			send_word(values[i]);
			maybe_idle(1'b1);
		end
	endtask

	task automatic test_random_mix(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_word(random_number());
			if (i == count / 2)
				wait_for_results();
			else
				maybe_idle(1'b1);
		end
	endtask

	task automatic test_back_to_back(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_word(random_number());
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		number = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_pseudoprimes();
		test_random_mix(70);
		test_back_to_back(25);

		wait_for_results();
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("[miller_rabin_prime_test] OK");
		else
			$display("[miller_rabin_prime_test] ERROR");
		$finish;
	end

endmodule
